### rtl/core/msf_pkg.sv
// Shared types, constants and helpers for the Manhattan nearest-seed fill unit.
`default_nettype none

package msf_pkg;

  localparam int MAX_SIDE   = 32;
  localparam int VALUE_BITS = 16;

  localparam int CELLS      = MAX_SIDE * MAX_SIDE;
  localparam int IDX_BITS   = $clog2(CELLS);
  localparam int COUNT_BITS = $clog2(CELLS + 1);
  localparam int COORD_BITS = $clog2(MAX_SIDE);
  localparam int SIDE_BITS  = $clog2(MAX_SIDE + 1);
  localparam int DIST_BITS  = COORD_BITS + 1;
  localparam int CFG_BITS   = 6;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_GRID_SIDE = '0;
  localparam logic [CFG_BITS-1:0]      GRID_SIDE_RESET = CFG_BITS'(MAX_SIDE);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_REJECT
  } op_t;

  typedef enum logic [2:0] {
    STAT_ORIGINAL = 3'd0,
    STAT_FILLED   = 3'd1,
    STAT_TIE      = 3'd2,
    STAT_NO_SEED  = 3'd3,
    STAT_OUTSIDE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OWN,
    S_SCAN,
    S_FETCH
  } back_state_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    op_t                   op;
    logic                  restart;
    logic [VALUE_BITS-1:0] value;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
  } req_t;

  function automatic logic [IDX_BITS-1:0] cell_idx(input logic [COORD_BITS-1:0] row,
                                                   input logic [COORD_BITS-1:0] col);
    return IDX_BITS'(int'(row) * MAX_SIDE + int'(col));
  endfunction

  // Clamp the programmed side into 1..MAX_SIDE.
  function automatic logic [SIDE_BITS-1:0] eff_side(input logic [CFG_BITS-1:0] g);
    logic [SIDE_BITS-1:0] s;
    if (g == '0) begin
      s = SIDE_BITS'(1);
    end else if (int'(g) > MAX_SIDE) begin
      s = SIDE_BITS'(MAX_SIDE);
    end else begin
      s = SIDE_BITS'(g);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/core/manhattan_nearest_seed_fill_unit.sv
// Top level of the Manhattan nearest-seed fill unit with its APB register port.
`default_nettype none

// Load requests (action 0) fill a square grid row by row, one value each; the
// side is taken from grid_side when a load opens a new grid (side 0 reads as
// 1, sides above 32 as 32) and the grid is ready once its last cell is loaded.
// A query request (action 1) returns one result: the cell's own value if it is
// nonzero, else the value of the single nearest nonzero cell by Manhattan
// distance, else zero with a tie, no-seed or outside-grid status. A request is
// taken at a clock edge with start high and busy low; busy rises only when the
// four-deep request queue between the front end and the back end is full. The
// back end writes each load into the grid store, a nonzero one also into the
// seed store, and answers each query through the outside, own-value or no-seed
// cases or else a scan of the seed store, whose single read port yields one
// seed per cycle. Each result shows on filled_value and status for exactly one
// cycle with done high, and there is no way to hold it off: capture it.
// Program grid_side at byte address 0 only while the unit is idle.
module manhattan_nearest_seed_fill_unit (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // request port
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic                                    action,
  input  wire logic signed [msf_pkg::VALUE_BITS-1:0]   cell_value,
  input  wire logic [msf_pkg::COORD_BITS-1:0]          query_row,
  input  wire logic [msf_pkg::COORD_BITS-1:0]          query_col,
  // result port
  output logic                                         done,
  output logic signed [msf_pkg::VALUE_BITS-1:0]        filled_value,
  output logic [2:0]                                   status,
  // configuration port
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic [msf_pkg::APB_ADDR_BITS-1:0]       paddr,
  input  wire logic [msf_pkg::APB_DATA_BITS-1:0]       pwdata,
  output logic [msf_pkg::APB_DATA_BITS-1:0]            prdata,
  output logic                                         pready
);
  import msf_pkg::*;

  logic [CFG_BITS-1:0] grid_side;
  logic                cfg_write;

  logic                q_push;
  req_t                q_push_data;
  logic                q_full;
  logic                q_pop;
  req_t                q_head;
  logic                q_empty;
  status_t             back_status;

  // Zero wait states: every access completes in its access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_GRID_SIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= GRID_SIDE_RESET;
    end else if (cfg_write) begin
      grid_side <= pwdata[CFG_BITS-1:0];
    end
  end

  // Reads of unmapped addresses return zero.
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_GRID_SIDE) begin
      prdata = APB_DATA_BITS'(grid_side);
    end
  end

  // Front: take requests, track the load position, classify queries.
  msf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .cell_value (cell_value),
    .query_row  (query_row),
    .query_col  (query_col),
    .grid_side  (grid_side),
    .full       (q_full),
    .busy       (busy),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  // Queue: lets the front keep taking loads while the back scans.
  msf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back: stores, load writes and the nearest-seed scan.
  msf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .head         (q_head),
    .pop          (q_pop),
    .done         (done),
    .filled_value (filled_value),
    .status       (back_status)
  );

  assign status = back_status;

endmodule

`default_nettype wire

### rtl/core/msf_front.sv
// Front end: accepts requests, tracks the load position and classifies queries.
`default_nettype none

module msf_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            action,
  input  wire logic [msf_pkg::VALUE_BITS-1:0]  cell_value,
  input  wire logic [msf_pkg::COORD_BITS-1:0]  query_row,
  input  wire logic [msf_pkg::COORD_BITS-1:0]  query_col,
  input  wire logic [msf_pkg::CFG_BITS-1:0]    grid_side,
  input  wire logic                            full,
  output logic                                 busy,
  output logic                                 push,
  output msf_pkg::req_t                        push_data
);
  import msf_pkg::*;

  logic                  at_start, at_start_next;
  logic                  ready, ready_next;
  logic [COORD_BITS-1:0] row, row_next;
  logic [COORD_BITS-1:0] col, col_next;
  logic [SIDE_BITS-1:0]  load_side, load_side_next;
  logic [SIDE_BITS-1:0]  side_now;
  logic                  last_col;
  logic                  last_row;
  logic                  outside;

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    at_start_next  = at_start;
    ready_next     = ready;
    row_next       = row;
    col_next       = col;
    load_side_next = load_side;

    // Latch the side only when a load opens a new grid.
    side_now = at_start ? eff_side(grid_side) : load_side;
    last_col = (SIDE_BITS'(col) + SIDE_BITS'(1)) == side_now;
    last_row = (SIDE_BITS'(row) + SIDE_BITS'(1)) == side_now;
    outside  = !ready || (SIDE_BITS'(query_row) >= load_side)
                      || (SIDE_BITS'(query_col) >= load_side);

    push_data.value   = cell_value;
    push_data.restart = at_start;
    if (action == ACT_LOAD) begin
      push_data.op  = OP_LOAD;
      push_data.row = row;
      push_data.col = col;
    end else begin
      push_data.op  = outside ? OP_REJECT : OP_QUERY;
      push_data.row = query_row;
      push_data.col = query_col;
    end

    if (push && action == ACT_LOAD) begin
      load_side_next = side_now;
      if (last_col && last_row) begin
        row_next      = '0;
        col_next      = '0;
        at_start_next = 1'b1;
        ready_next    = 1'b1;
      end else begin
        at_start_next = 1'b0;
        ready_next    = at_start ? 1'b0 : ready;
        if (last_col) begin
          col_next = '0;
          row_next = row + COORD_BITS'(1);
        end else begin
          col_next = col + COORD_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start  <= 1'b1;
      ready     <= 1'b0;
      row       <= '0;
      col       <= '0;
      load_side <= SIDE_BITS'(1);
    end else begin
      at_start  <= at_start_next;
      ready     <= ready_next;
      row       <= row_next;
      col       <= col_next;
      load_side <= load_side_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/msf_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none

module msf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire msf_pkg::req_t push_data,
  output logic               full,
  input  wire logic          pop,
  output msf_pkg::req_t      head,
  output logic               empty
);
  import msf_pkg::*;

  req_t                 slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full  = count == QCNT_BITS'(QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QDEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue popped while empty");

  a_push_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + QCNT_BITS'(1)))
    else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

### rtl/core/msf_back.sv
// Back end: grid and seed stores, load writes and the seed distance scan.
`default_nettype none

module msf_back (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   empty,
  input  wire msf_pkg::req_t                          head,
  output logic                                        pop,
  output logic                                        done,
  output logic signed [msf_pkg::VALUE_BITS-1:0]       filled_value,
  output msf_pkg::status_t                            status
);
  import msf_pkg::*;

  localparam int SEED_BITS = 2 * COORD_BITS;

  logic [VALUE_BITS-1:0] cell_mem [CELLS];
  logic [SEED_BITS-1:0]  seed_mem [CELLS];

  back_state_t           state, state_next;
  logic [COUNT_BITS-1:0] seed_count, seed_count_next;
  logic [COORD_BITS-1:0] q_row, q_row_next;
  logic [COORD_BITS-1:0] q_col, q_col_next;
  logic [COUNT_BITS-1:0] scan_k, scan_k_next;
  logic                  scan_vld, scan_vld_next;
  logic [DIST_BITS-1:0]  best_dist, best_dist_next;
  logic [COORD_BITS-1:0] best_row, best_row_next;
  logic [COORD_BITS-1:0] best_col, best_col_next;
  logic                  tie, tie_next;
  logic                  done_next;
  logic [VALUE_BITS-1:0] value_next;
  status_t               status_next;

  logic                  cell_we;
  logic [IDX_BITS-1:0]   cell_waddr;
  logic                  cell_re;
  logic [IDX_BITS-1:0]   cell_raddr;
  logic [VALUE_BITS-1:0] cell_rdata;
  logic                  seed_we;
  logic [IDX_BITS-1:0]   seed_waddr;
  logic                  seed_re;
  logic [IDX_BITS-1:0]   seed_raddr;
  logic [SEED_BITS-1:0]  seed_rdata;

  logic [COORD_BITS-1:0] s_row;
  logic [COORD_BITS-1:0] s_col;
  logic [COORD_BITS-1:0] d_row;
  logic [COORD_BITS-1:0] d_col;
  logic [DIST_BITS-1:0]  span;
  logic                  nz;

  assign s_row = seed_rdata[SEED_BITS-1:COORD_BITS];
  assign s_col = seed_rdata[COORD_BITS-1:0];
  assign d_row = (s_row > q_row) ? s_row - q_row : q_row - s_row;
  assign d_col = (s_col > q_col) ? s_col - q_col : q_col - s_col;
  assign span  = DIST_BITS'(d_row) + DIST_BITS'(d_col);
  assign nz    = head.value != '0;

  always_comb begin
    state_next      = state;
    seed_count_next = seed_count;
    q_row_next      = q_row;
    q_col_next      = q_col;
    scan_k_next     = scan_k;
    scan_vld_next   = scan_vld;
    best_dist_next  = best_dist;
    best_row_next   = best_row;
    best_col_next   = best_col;
    tie_next        = tie;
    done_next       = 1'b0;
    value_next      = filled_value;
    status_next     = status;
    pop             = 1'b0;
    cell_we         = 1'b0;
    cell_waddr      = cell_idx(head.row, head.col);
    cell_re         = 1'b0;
    cell_raddr      = cell_idx(head.row, head.col);
    seed_we         = 1'b0;
    seed_waddr      = head.restart ? '0 : seed_count[IDX_BITS-1:0];
    seed_re         = 1'b0;
    seed_raddr      = scan_k[IDX_BITS-1:0];

    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          unique case (head.op)
            OP_LOAD: begin
              cell_we = 1'b1;
              seed_we = nz;
              if (head.restart) begin
                seed_count_next = COUNT_BITS'(nz);
              end else begin
                seed_count_next = seed_count + COUNT_BITS'(nz);
              end
            end
            OP_QUERY: begin
              cell_re    = 1'b1;
              q_row_next = head.row;
              q_col_next = head.col;
              state_next = S_OWN;
            end
            OP_REJECT: begin
              done_next   = 1'b1;
              value_next  = '0;
              status_next = STAT_OUTSIDE;
            end
            default: begin
              done_next = 1'b0;
            end
          endcase
        end
      end
      S_OWN: begin
        if (cell_rdata != '0) begin
          done_next   = 1'b1;
          value_next  = cell_rdata;
          status_next = STAT_ORIGINAL;
          state_next  = S_IDLE;
        end else if (seed_count == '0) begin
          done_next   = 1'b1;
          value_next  = '0;
          status_next = STAT_NO_SEED;
          state_next  = S_IDLE;
        end else begin
          // Launch the first seed read and open the scan.
          seed_re        = 1'b1;
          seed_raddr     = '0;
          scan_k_next    = COUNT_BITS'(1);
          scan_vld_next  = 1'b1;
          best_dist_next = '1;
          tie_next       = 1'b0;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_vld) begin
          if (span < best_dist) begin
            best_dist_next = span;
            best_row_next  = s_row;
            best_col_next  = s_col;
            tie_next       = 1'b0;
          end else if (span == best_dist) begin
            tie_next = 1'b1;
          end
          if (scan_k < seed_count) begin
            seed_re       = 1'b1;
            scan_k_next   = scan_k + COUNT_BITS'(1);
            scan_vld_next = 1'b1;
          end else begin
            scan_vld_next = 1'b0;
          end
        end else begin
          // Scan drained: fetch the winning seed's value.
          cell_re    = 1'b1;
          cell_raddr = cell_idx(best_row, best_col);
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (tie) begin
          value_next  = '0;
          status_next = STAT_TIE;
        end else begin
          value_next  = cell_rdata;
          status_next = STAT_FILLED;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= head.value;
    end
    if (cell_re) begin
      cell_rdata <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (seed_we) begin
      seed_mem[seed_waddr] <= {head.row, head.col};
    end
    if (seed_re) begin
      seed_rdata <= seed_mem[seed_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seed_count <= '0;
      scan_vld   <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      seed_count <= seed_count_next;
      scan_vld   <= scan_vld_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    q_row        <= q_row_next;
    q_col        <= q_col_next;
    scan_k       <= scan_k_next;
    best_dist    <= best_dist_next;
    best_row     <= best_row_next;
    best_col     <= best_col_next;
    tie          <= tie_next;
    filled_value <= value_next;
    status       <= status_next;
  end

`ifndef SYNTHESIS
  a_seed_bound: assert property (@(posedge clk) disable iff (rst)
    seed_count <= COUNT_BITS'(CELLS))
    else $error("seed count above grid capacity");

  a_zero_results: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_TIE || status == STAT_NO_SEED || status == STAT_OUTSIDE))
      |-> filled_value == '0)
    else $error("nonzero value on a tie, empty or outside result");

  a_original_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_ORIGINAL) |-> filled_value != '0)
    else $error("original result carries zero");

  a_scan_in_state: assert property (@(posedge clk) disable iff (rst)
    scan_vld |-> state == S_SCAN)
    else $error("seed read data pending outside the scan");

  a_fetch_done: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |=> done && state == S_IDLE)
    else $error("fetch did not finish the query");
`endif

endmodule

`default_nettype wire
